// ===== rtl/ctli_pkg.sv =====
// shared types and constants for the clamped table linear interpolator
package ctli_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int FRACTION_BITS = 16;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int DATA_W        = 32;
    localparam int ENTRY_IDX_W   = 10;
    localparam int SAMPLES_W     = 11;
    localparam int CFG_IDX_W     = 3;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int DIFF_W        = DATA_W + 1;
    localparam int BLEND_W       = DIFF_W + FRACTION_BITS + 1;
    localparam int MAX_IDX_LIMIT = TABLE_DEPTH - 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_POINT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POINT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_AT_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_AT_END   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_IN_USE = 3'd5;

    // 1.0 in unsigned Q16.16
    localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'h0001_0000;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [1:0] {
        SEL_MID   = 2'd0,
        SEL_START = 2'd1,
        SEL_END   = 2'd2
    } t_sel;

    typedef struct packed {
        logic signed [DATA_W-1:0] start_point;
        logic signed [DATA_W-1:0] end_point;
        logic        [DATA_W-1:0] inverse_step;
        logic signed [DATA_W-1:0] value_at_start;
        logic signed [DATA_W-1:0] value_at_end;
        logic        [ADDR_W-1:0] max_idx;
    } t_cfg;

    typedef struct packed {
        logic                     func;
        logic [ENTRY_IDX_W-1:0]   entry_index;
        logic [DATA_W-1:0]        entry_value;
        t_sel                     sel;
        logic [ADDR_W-1:0]        idx;
        logic [FRACTION_BITS-1:0] frac;
        logic                     last;
    } t_lookup;

    typedef struct packed {
        t_sel                     sel;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [FRACTION_BITS-1:0] frac;
        logic                     last;
    } t_sample;

endpackage

// ===== rtl/ctli_scale.sv =====
// range check, scaling multiply and index saturation (three stages)
module ctli_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ctli_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [ctli_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic [ctli_pkg::DATA_W-1:0]         i_entry_value,
    input  logic [ctli_pkg::DATA_W-1:0]         i_x_value,
    input  logic                                i_batch_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output ctli_pkg::t_lookup                   o_word
);
    import ctli_pkg::*;

    logic              en_a, en_b, en_c;
    logic              r_a_vld, r_b_vld, r_c_vld;
    t_lookup           r_a_word, r_b_word, r_c_word;
    t_lookup           n_a_word, n_c_word;
    logic [DATA_W-1:0] r_a_d, n_a_d;
    logic [PROD_W-1:0] r_b_prod;
    logic [DATA_W-1:0] idx_whole;

    assign en_c    = !r_c_vld || i_ready;
    assign en_b    = !r_b_vld || en_c;
    assign en_a    = !r_a_vld || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_vld;
    assign o_word  = r_c_word;

    // stage a: bound tests and offset from the start point
    always_comb begin
        n_a_word             = '0;
        n_a_word.func        = i_func;
        n_a_word.entry_index = i_entry_index;
        n_a_word.entry_value = i_entry_value;
        n_a_word.last        = i_batch_last;
        if ($signed(i_x_value) <= i_cfg.start_point) begin
            n_a_word.sel = SEL_START;
        end else if ($signed(i_x_value) >= i_cfg.end_point) begin
            n_a_word.sel = SEL_END;
        end else begin
            n_a_word.sel = SEL_MID;
        end
        n_a_d = i_x_value - i_cfg.start_point;
    end

    // stage c: integer part saturates at the last usable pair
    always_comb begin
        n_c_word      = r_b_word;
        idx_whole     = r_b_prod[PROD_W-1:DATA_W];
        n_c_word.frac = r_b_prod[DATA_W-1 -: FRACTION_BITS];
        if (idx_whole > DATA_W'(i_cfg.max_idx)) begin
            n_c_word.idx = i_cfg.max_idx;
        end else begin
            n_c_word.idx = idx_whole[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_vld <= i_valid;
            end
            if (en_b) begin
                r_b_vld <= r_a_vld;
            end
            if (en_c) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_word <= n_a_word;
            r_a_d    <= n_a_d;
        end
        if (en_b) begin
            r_b_word <= r_a_word;
            r_b_prod <= PROD_W'(r_a_d) * PROD_W'(i_cfg.inverse_step);
        end
        if (en_c) begin
            r_c_word <= n_c_word;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld && r_c_word.func == FUNC_EVAL |-> r_c_word.idx <= i_cfg.max_idx)
        else $error("lookup index beyond last usable pair");

endmodule

// ===== rtl/ctli_table.sv =====
// sample memory: loads write, evaluations read both neighbors
module ctli_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ctli_pkg::t_lookup i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output ctli_pkg::t_sample o_word
);
    import ctli_pkg::*;

    logic [DATA_W-1:0] r_mem [TABLE_DEPTH];
    logic              en;
    logic              wr_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] idx_b;
    logic              r_vld;
    t_sample           r_word;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_word  = r_word;
    assign wr_ok   = 32'(i_word.entry_index) < TABLE_DEPTH;
    assign wr_en   = en && i_valid && i_word.func == FUNC_LOAD && wr_ok;
    assign idx_b   = i_word.idx + ADDR_W'(1);

    // loads end here and leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid && i_word.func == FUNC_EVAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ADDR_W'(i_word.entry_index)] <= i_word.entry_value;
        end
        if (en) begin
            r_word.a    <= r_mem[i_word.idx];
            r_word.b    <= r_mem[idx_b];
            r_word.sel  <= i_word.sel;
            r_word.frac <= i_word.frac;
            r_word.last <= i_word.last;
        end
    end

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && i_valid && i_word.func == FUNC_LOAD |=> !r_vld)
        else $error("load produced a result word");

endmodule

// ===== rtl/ctli_blend.sv =====
// difference, fraction multiply, floor and end-value select (three stages)
module ctli_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ctli_pkg::t_cfg              i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ctli_pkg::t_sample           i_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ctli_pkg::DATA_W-1:0] o_y_value,
    output logic                        o_last_out
);
    import ctli_pkg::*;

    logic                       en_d, en_e, en_f;
    logic                       r_d_vld, r_e_vld, r_f_vld;
    t_sel                       r_d_sel, r_e_sel;
    logic                       r_d_last, r_e_last, r_f_last;
    logic signed [DATA_W-1:0]   r_d_a, r_e_a;
    logic signed [DIFF_W-1:0]   r_d_diff;
    logic [FRACTION_BITS-1:0]   r_d_frac;
    logic signed [BLEND_W-1:0]  r_e_t;
    logic signed [BLEND_W-1:0]  n_q;
    logic [DATA_W-1:0]          r_f_y, n_f_y;

    assign en_f       = !r_f_vld || i_ready;
    assign en_e       = !r_e_vld || en_f;
    assign en_d       = !r_d_vld || en_e;
    assign o_ready    = en_d;
    assign o_valid    = r_f_vld;
    assign o_y_value  = r_f_y;
    assign o_last_out = r_f_last;

    // arithmetic shift gives the floor
    always_comb begin
        n_q = r_e_t >>> FRACTION_BITS;
        unique case (r_e_sel)
            SEL_START: n_f_y = i_cfg.value_at_start;
            SEL_END:   n_f_y = i_cfg.value_at_end;
            default:   n_f_y = r_e_a + n_q[DATA_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            if (en_d) begin
                r_d_vld <= i_valid;
            end
            if (en_e) begin
                r_e_vld <= r_d_vld;
            end
            if (en_f) begin
                r_f_vld <= r_e_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_diff <= DIFF_W'(i_word.b) - DIFF_W'(i_word.a);
            r_d_a    <= i_word.a;
            r_d_frac <= i_word.frac;
            r_d_sel  <= i_word.sel;
            r_d_last <= i_word.last;
        end
        if (en_e) begin
            r_e_t    <= BLEND_W'(r_d_diff) * BLEND_W'($signed({1'b0, r_d_frac}));
            r_e_a    <= r_d_a;
            r_e_sel  <= r_d_sel;
            r_e_last <= r_d_last;
        end
        if (en_f) begin
            r_f_y    <= n_f_y;
            r_f_last <= r_e_last;
        end
    end

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_vld && !en_f |=> r_e_vld && $stable(r_e_t))
        else $error("product stage lost or changed a word under stall");

endmodule

// ===== rtl/clamped_table_linear_interpolator_core.sv =====
// top level: configuration registers and the interpolation pipeline
// Evaluates a function from a table of up to 1024 uniformly spaced samples.
// Load words write one sample; evaluate words return one interpolated value in
// signed Q16.16, clamped to the configured end values outside the interval.
// One word is taken per clock unless back-pressure stalls the pipeline; each word passes
// seven register stages: three scaling stages with one 32x32 multiply,
// the registered table read, and three blend stages with one 33x17 multiply.
// Back-pressure on the output stalls stage by stage, so empty stages still fill
// while the output waits.
// Table entries have no reset value; evaluate only points whose neighbors were loaded.
// Configuration must be written only while no word is in flight; the block does not enforce it.
module clamped_table_linear_interpolator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ctli_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ctli_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic [ctli_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic [ctli_pkg::DATA_W-1:0]         i_entry_value,
    input  logic [ctli_pkg::DATA_W-1:0]         i_x_value,
    input  logic                                i_batch_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ctli_pkg::DATA_W-1:0]         o_y_value,
    output logic                                o_last_out
);
    import ctli_pkg::*;

    t_cfg                 r_cfg;
    logic [SAMPLES_W-1:0] cfg_samples;
    logic [ADDR_W-1:0]    n_max_idx;
    logic                 scale_vld, scale_rdy;
    t_lookup              scale_word;
    logic                 tbl_vld, tbl_rdy;
    t_sample              tbl_word;

    // last usable pair index from the clamped sample count
    always_comb begin
        cfg_samples = i_cfg_data[SAMPLES_W-1:0];
        if (cfg_samples < SAMPLES_W'(2)) begin
            n_max_idx = '0;
        end else if (32'(cfg_samples) > TABLE_DEPTH) begin
            n_max_idx = ADDR_W'(MAX_IDX_LIMIT);
        end else begin
            n_max_idx = ADDR_W'(cfg_samples - SAMPLES_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_point    <= '0;
            r_cfg.end_point      <= '0;
            r_cfg.inverse_step   <= INV_STEP_RESET;
            r_cfg.value_at_start <= '0;
            r_cfg.value_at_end   <= '0;
            r_cfg.max_idx        <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_START_POINT:    r_cfg.start_point    <= i_cfg_data;
                REG_END_POINT:      r_cfg.end_point      <= i_cfg_data;
                REG_INVERSE_STEP:   r_cfg.inverse_step   <= i_cfg_data;
                REG_VALUE_AT_START: r_cfg.value_at_start <= i_cfg_data;
                REG_VALUE_AT_END:   r_cfg.value_at_end   <= i_cfg_data;
                REG_SAMPLES_IN_USE: r_cfg.max_idx        <= n_max_idx;
                default: ;
            endcase
        end
    end

    ctli_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_x_value     (i_x_value),
        .i_batch_last  (i_batch_last),
        .o_valid       (scale_vld),
        .i_ready       (scale_rdy),
        .o_word        (scale_word)
    );

    ctli_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (scale_vld),
        .o_ready (scale_rdy),
        .i_word  (scale_word),
        .o_valid (tbl_vld),
        .i_ready (tbl_rdy),
        .o_word  (tbl_word)
    );

    ctli_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (tbl_vld),
        .o_ready    (tbl_rdy),
        .i_word     (tbl_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_y_value  (o_y_value),
        .o_last_out (o_last_out)
    );

    a_max_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en && i_cfg_index == REG_SAMPLES_IN_USE
        |=> r_cfg.max_idx <= ADDR_W'(MAX_IDX_LIMIT))
        else $error("sample count clamp let the pair index pass the table end");

endmodule
